// ===== rtl/core/cs_pkg.sv =====
package cs_pkg;

   localparam int MAX_PROCESSES = 8;
   localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic signed [7:0] cred_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      PS_WAIT  = 2'd0,
      PS_RUN   = 2'd1,
      PS_BLOCK = 2'd2
   } pstate_type;

   typedef struct packed {
      pstate_type  state;
      logic [4:0]  prio;
      logic [7:0]  burst;
      logic [15:0] burst_left;
      logic [7:0]  io_time;
      logic [15:0] io_left;
      logic [11:0] cpu_left;
   } slot_rec_type;

   typedef enum logic [2:0] {
      LOP_NONE,
      LOP_APPEND,
      LOP_SET_CRED,
      LOP_SORT,
      LOP_HEAD
   } list_op_type;

   typedef enum logic [1:0] {
      HD_KEEP,
      HD_REMOVE,
      HD_ROTATE
   } head_op_type;

   typedef struct packed {
      list_op_type op;
      head_op_type hd;
      slot_type    pos;
      slot_type    slot;
      cred_type    cred;
      logic        tie;
      logic        phase;
   } list_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_SORT,
      ST_BLK_RD,
      ST_BLK_WR,
      ST_REC_RD,
      ST_REC_WR,
      ST_REC_SORT,
      ST_HEAD_RD,
      ST_HEAD_WR,
      ST_HEAD_SORT,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_SINGLE
   } fsm_type;

   function automatic cred_type sat8(input logic signed [9:0] v);
      cred_type r;
      if (v > 10'sd127) r = 8'sd127;
      else if (v < -10'sd128) r = -8'sd128;
      else r = v[7:0];
      return r;
   endfunction

   function automatic logic [2:0] to_index(input slot_type s);
      logic [31:0] w;
      w = 32'(s);
      return w[2:0];
   endfunction

endpackage

// ===== rtl/core/cs_slot_ram.sv =====
module cs_slot_ram
   import cs_pkg::*;
(
   input  logic         clock,
   input  logic         wr_en,
   input  slot_type     wr_addr,
   input  slot_rec_type wr_data,
   input  slot_type     rd_addr,
   output slot_rec_type rd_data
);

   slot_rec_type mem [MAX_PROCESSES];
   slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cs_order_list.sv =====
module cs_order_list
   import cs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  list_cmd_type cmd,
   input  slot_type     rd_pos,
   output cnt_type      count,
   output slot_type     rd_slot,
   output cred_type     rd_cred
);

   slot_type ord_ff  [MAX_PROCESSES];
   slot_type ord_in  [MAX_PROCESSES];
   cred_type cred_ff [MAX_PROCESSES];
   cred_type cred_in [MAX_PROCESSES];
   cnt_type  cnt_ff;
   cnt_type  cnt_in;

   always_comb begin
      ord_in  = ord_ff;
      cred_in = cred_ff;
      cnt_in  = cnt_ff;
      unique case (cmd.op)
         LOP_APPEND: begin
            ord_in[cnt_ff[SLOT_W-1:0]]  = cmd.slot;
            cred_in[cnt_ff[SLOT_W-1:0]] = cmd.cred;
            cnt_in = cnt_ff + cnt_type'(1);
         end
         LOP_SET_CRED: begin
            cred_in[cmd.pos] = cmd.cred;
         end
         LOP_SORT: begin
            // one odd-even pass; stable, but cmd.tie orders equal credits by slot
            for (int j = 0; j < MAX_PROCESSES - 1; j++) begin
               if ((((j % 2) == 1) == cmd.phase) && (cnt_type'(j + 1) < cnt_ff)) begin
                  if ((cred_ff[j+1] > cred_ff[j]) ||
                      ((cred_ff[j+1] == cred_ff[j]) && cmd.tie &&
                       (ord_ff[j+1] < ord_ff[j]))) begin
                     ord_in[j]    = ord_ff[j+1];
                     ord_in[j+1]  = ord_ff[j];
                     cred_in[j]   = cred_ff[j+1];
                     cred_in[j+1] = cred_ff[j];
                  end
               end
            end
         end
         LOP_HEAD: begin
            cred_in[0] = cmd.cred;
            unique case (cmd.hd)
               HD_REMOVE: begin
                  for (int i = 0; i < MAX_PROCESSES - 1; i++) begin
                     ord_in[i]  = ord_ff[i+1];
                     cred_in[i] = cred_ff[i+1];
                  end
                  cnt_in = cnt_ff - cnt_type'(1);
               end
               HD_ROTATE: begin
                  for (int i = 0; i < MAX_PROCESSES; i++) begin
                     if (cnt_type'(i + 1) < cnt_ff) begin
                        ord_in[i]  = ord_ff[(i + 1) % MAX_PROCESSES];
                        cred_in[i] = cred_ff[(i + 1) % MAX_PROCESSES];
                     end else if (cnt_type'(i + 1) == cnt_ff) begin
                        ord_in[i]  = ord_ff[0];
                        cred_in[i] = cmd.cred;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ord_ff  <= ord_in;
      cred_ff <= cred_in;
   end

   assign count   = cnt_ff;
   assign rd_slot = ord_ff[rd_pos];
   assign rd_cred = cred_ff[rd_pos];

endmodule

// ===== rtl/core/credit_cpu_scheduler_core.sv =====
// Credit scheduler for up to MAX_PROCESSES processes. One command word at a time:
// a load does one slot write, then odd-even sort passes over the order list, and
// returns one word; a load past MAX_PROCESSES returns one rejected word. A tick
// on a list of n entries walks the blocked counters over all n entries,
// recomputes the credits and re-sorts when no entry is active, updates the head,
// re-sorts when the head forces it, and emits the list; a tick on an empty list
// returns one word. Each slot memory access has a read state and a modify/write
// state, and output stalls hold the emit. A new command is taken as soon as the
// last word of the previous one sits in the output register.
module credit_cpu_scheduler_core
   import cs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [4:0]         req_priority_req,
   input  logic [7:0]         req_burst_length,
   input  logic [7:0]         req_io_time,
   input  logic [11:0]        req_cpu_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_present,
   output logic [2:0]         rsp_load_index,
   output logic [1:0]         rsp_proc_state,
   output logic signed [7:0]  rsp_credits,
   output logic signed [15:0] rsp_burst_left,
   output logic signed [15:0] rsp_io_left,
   output logic [11:0]        rsp_cpu_left,
   output logic [4:0]         rsp_prio_out,
   output logic               rsp_load_rejected,
   output logic               rsp_last
);

   fsm_type      state_ff, state_in;
   cnt_type      idx_ff, idx_in;
   cnt_type      step_ff, step_in;
   cnt_type      loads_ff, loads_in;
   logic         active_ff, active_in;
   logic         tie_ff, tie_in;
   logic [2:0]   single_idx_ff, single_idx_in;
   logic         single_rej_ff, single_rej_in;

   logic         ram_we;
   slot_type     ram_waddr;
   slot_rec_type ram_wdata;
   slot_rec_type rd;

   list_cmd_type lcmd;
   cnt_type      list_cnt;
   slot_type     rd_slot;
   cred_type     rd_cred;

   logic         out_free;
   logic         out_load;
   logic         idx_last;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               present_ff, present_in;
   logic [2:0]         load_index_ff, load_index_in;
   logic [1:0]         proc_state_ff, proc_state_in;
   logic signed [7:0]  credits_ff, credits_in;
   logic signed [15:0] burst_left_ff, burst_left_in;
   logic signed [15:0] io_left_ff, io_left_in;
   logic [11:0]        cpu_left_ff, cpu_left_in;
   logic [4:0]         prio_ff, prio_in;
   logic               rej_ff, rej_in;
   logic               last_ff, last_in;

   slot_rec_type       nrec;
   cred_type           half;
   logic signed [9:0]  recalc;
   cred_type           ncred;
   pstate_type         hst;
   logic [15:0]        nbl;
   logic [11:0]        ncpu;
   head_op_type        hd;
   logic               need_sort;

   cs_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_slot),
      .rd_data (rd)
   );

   cs_order_list u_list (
      .clock   (clock),
      .reset   (reset),
      .cmd     (lcmd),
      .rd_pos  (idx_ff[SLOT_W-1:0]),
      .count   (list_cnt),
      .rd_slot (rd_slot),
      .rd_cred (rd_cred)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_last = (idx_ff + cnt_type'(1)) == list_cnt;
   assign half     = rd_cred / 8'sd2;
   assign recalc   = {{2{half[7]}}, half} + $signed({5'b0, rd.prio});

   // head update
   always_comb begin
      hst       = rd.state;
      nbl       = rd.burst_left;
      ncpu      = rd.cpu_left;
      ncred     = rd_cred;
      hd        = HD_KEEP;
      need_sort = 1'b0;
      if (hst == PS_WAIT) hst = PS_RUN;
      if (hst == PS_RUN) begin
         nbl   = rd.burst_left - 16'd1;
         ncred = sat8({{2{rd_cred[7]}}, rd_cred} - 10'sd1);
         ncpu  = rd.cpu_left - 12'd1;
         if (ncpu == 12'd0) begin
            hd        = HD_REMOVE;
            need_sort = 1'b1;
         end else if (nbl == 16'd0) begin
            hst = PS_BLOCK;
            hd  = HD_ROTATE;
         end else if (ncred == 8'sd0) begin
            hst       = PS_WAIT;
            hd        = HD_ROTATE;
            need_sort = 1'b1;
         end
      end else if (hst == PS_BLOCK) begin
         hd = HD_ROTATE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      loads_in      = loads_ff;
      active_in     = active_ff;
      tie_in        = tie_ff;
      single_idx_in = single_idx_ff;
      single_rej_in = single_rej_ff;
      ram_we        = 1'b0;
      ram_waddr     = rd_slot;
      ram_wdata     = rd;
      nrec          = rd;
      lcmd          = '{op: LOP_NONE, hd: HD_KEEP, pos: idx_ff[SLOT_W-1:0],
                        slot: loads_ff[SLOT_W-1:0], cred: rd_cred,
                        tie: tie_ff, phase: step_ff[0]};
      out_load      = 1'b0;
      present_in    = 1'b1;
      load_index_in = to_index(rd_slot);
      proc_state_in = rd.state;
      credits_in    = rd_cred;
      burst_left_in = $signed(rd.burst_left);
      io_left_in    = $signed(rd.io_left);
      cpu_left_in   = rd.cpu_left;
      prio_in       = rd.prio;
      rej_in        = 1'b0;
      last_in       = idx_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in    = '0;
               step_in   = '0;
               active_in = 1'b0;
               if (req_command == CMD_LOAD) begin
                  if (loads_ff >= cnt_type'(MAX_PROCESSES)) begin
                     single_idx_in = 3'd0;
                     single_rej_in = 1'b1;
                     state_in      = ST_SINGLE;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = loads_ff[SLOT_W-1:0];
                     ram_wdata = '{state: PS_WAIT, prio: req_priority_req,
                                   burst: req_burst_length,
                                   burst_left: {8'd0, req_burst_length},
                                   io_time: req_io_time,
                                   io_left: {8'd0, req_io_time},
                                   cpu_left: req_cpu_time};
                     lcmd.op       = LOP_APPEND;
                     lcmd.cred     = $signed({3'b0, req_priority_req});
                     single_idx_in = to_index(loads_ff[SLOT_W-1:0]);
                     single_rej_in = 1'b0;
                     loads_in      = loads_ff + cnt_type'(1);
                     tie_in        = 1'b1;
                     state_in      = ST_LOAD_SORT;
                  end
               end else if (list_cnt == '0) begin
                  single_idx_in = 3'd0;
                  single_rej_in = 1'b0;
                  state_in      = ST_SINGLE;
               end else begin
                  tie_in   = 1'b0;
                  state_in = ST_BLK_RD;
               end
            end
         end
         ST_LOAD_SORT, ST_REC_SORT, ST_HEAD_SORT: begin
            lcmd.op = LOP_SORT;
            step_in = step_ff + cnt_type'(1);
            if (step_ff == cnt_type'(MAX_PROCESSES - 1)) begin
               step_in = '0;
               idx_in  = '0;
               priority case (state_ff)
                  ST_LOAD_SORT: state_in = ST_SINGLE;
                  ST_REC_SORT:  state_in = ST_HEAD_RD;
                  default:      state_in = ST_EMIT_RD;
               endcase
            end
         end
         ST_BLK_RD: state_in = ST_BLK_WR;
         ST_BLK_WR: begin
            if (rd.state == PS_BLOCK) begin
               nrec.io_left = rd.io_left - 16'd1;
               if (nrec.io_left == 16'd0) begin
                  nrec.state      = PS_WAIT;
                  nrec.io_left    = {8'd0, rd.io_time};
                  nrec.burst_left = {8'd0, rd.burst};
               end
               ram_we = 1'b1;
            end
            ram_wdata = nrec;
            active_in = active_ff || ((rd_cred != 8'sd0) && (nrec.state != PS_BLOCK));
            idx_in    = idx_ff + cnt_type'(1);
            state_in  = ST_BLK_RD;
            if (idx_last) begin
               idx_in   = '0;
               state_in = active_in ? ST_HEAD_RD : ST_REC_RD;
            end
         end
         ST_REC_RD: state_in = ST_REC_WR;
         ST_REC_WR: begin
            lcmd.op   = LOP_SET_CRED;
            lcmd.cred = sat8(recalc);
            idx_in    = idx_ff + cnt_type'(1);
            state_in  = ST_REC_RD;
            if (idx_last) begin
               idx_in   = '0;
               step_in  = '0;
               state_in = ST_REC_SORT;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD_WR;
         ST_HEAD_WR: begin
            nrec.state      = hst;
            nrec.burst_left = nbl;
            nrec.cpu_left   = ncpu;
            ram_we          = 1'b1;
            ram_wdata       = nrec;
            lcmd.op         = LOP_HEAD;
            lcmd.hd         = hd;
            lcmd.cred       = ncred;
            step_in         = '0;
            state_in        = need_sort ? ST_HEAD_SORT : ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            if (list_cnt == '0) begin
               single_idx_in = 3'd0;
               single_rej_in = 1'b0;
               state_in      = ST_SINGLE;
            end else begin
               state_in = ST_EMIT_WR;
            end
         end
         ST_EMIT_WR: begin
            // hold until the output register is free
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff + cnt_type'(1);
               state_in = idx_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_SINGLE: begin
            present_in    = 1'b0;
            load_index_in = single_idx_ff;
            proc_state_in = 2'd0;
            credits_in    = '0;
            burst_left_in = '0;
            io_left_in    = '0;
            cpu_left_in   = '0;
            prio_in       = '0;
            rej_in        = single_rej_ff;
            last_in       = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loads_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loads_ff     <= loads_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      active_ff     <= active_in;
      tie_ff        <= tie_in;
      single_idx_ff <= single_idx_in;
      single_rej_ff <= single_rej_in;
      if (out_load) begin
         present_ff    <= present_in;
         load_index_ff <= load_index_in;
         proc_state_ff <= proc_state_in;
         credits_ff    <= credits_in;
         burst_left_ff <= burst_left_in;
         io_left_ff    <= io_left_in;
         cpu_left_ff   <= cpu_left_in;
         prio_ff       <= prio_in;
         rej_ff        <= rej_in;
         last_ff       <= last_in;
      end
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_present       = present_ff;
   assign rsp_load_index    = load_index_ff;
   assign rsp_proc_state    = proc_state_ff;
   assign rsp_credits       = credits_ff;
   assign rsp_burst_left    = burst_left_ff;
   assign rsp_io_left       = io_left_ff;
   assign rsp_cpu_left      = cpu_left_ff;
   assign rsp_prio_out      = prio_ff;
   assign rsp_load_rejected = rej_ff;
   assign rsp_last          = last_ff;

   a_cnt_le_loads: assert property (@(posedge clock) disable iff (reset)
      list_cnt <= loads_ff)
      else $error("list holds more entries than loads done");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten while stalled");

   a_loads_bounded: assert property (@(posedge clock) disable iff (reset)
      loads_ff <= cnt_type'(MAX_PROCESSES))
      else $error("load counter past table size");

endmodule

// ===== tb/credit_cpu_scheduler_core_test.sv =====
`timescale 1ns / 100ps

module credit_cpu_scheduler_core_test
   import cs_pkg::*;
();

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic        cmd;
      logic [4:0]  prio;
      logic [7:0]  burst;
      logic [7:0]  io;
      logic [11:0] cpu;
      bit          drain;
   } sched_cmd_type;

   typedef struct {
      logic               present;
      logic [2:0]         index;
      logic [1:0]         pstate;
      logic signed [7:0]  credits;
      logic signed [15:0] burst_left;
      logic signed [15:0] io_left;
      logic [11:0]        cpu_left;
      logic [4:0]         prio;
      logic               rejected;
      logic               last;
   } list_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_TICK;
   logic [4:0]         req_priority_req = '0;
   logic [7:0]         req_burst_length = '0;
   logic [7:0]         req_io_time = '0;
   logic [11:0]        req_cpu_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_present;
   logic [2:0]         rsp_load_index;
   logic [1:0]         rsp_proc_state;
   logic signed [7:0]  rsp_credits;
   logic signed [15:0] rsp_burst_left;
   logic signed [15:0] rsp_io_left;
   logic [11:0]        rsp_cpu_left;
   logic [4:0]         rsp_prio_out;
   logic               rsp_load_rejected;
   logic               rsp_last;

   credit_cpu_scheduler_core u_top (.*);

   sched_cmd_type pending_cmds[$];
   list_word_type expected_words[$];
   int            error_count = 0;
   int            word_count = 0;
   int            cycle_count = 0;

   // scheduler shadow state
   logic [2:0]  run_order[MAX_PROCESSES];
   int          run_count = 0;
   int          loaded = 0;
   pstate_type  proc_st[MAX_PROCESSES];
   int          proc_cred[MAX_PROCESSES];
   logic [4:0]  proc_prio[MAX_PROCESSES];
   logic [7:0]  proc_burst[MAX_PROCESSES];
   logic [15:0] proc_burst_left[MAX_PROCESSES];
   logic [7:0]  proc_io[MAX_PROCESSES];
   logic [15:0] proc_io_left[MAX_PROCESSES];
   logic [11:0] proc_cpu_left[MAX_PROCESSES];

   initial forever #5 clock = ~clock;

   function automatic void add_cmd(sched_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   function automatic void add_word(list_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic int clamp_cred(int v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return v;
   endfunction

   function automatic void sort_by_credits(bit tie_by_load);
      logic [2:0] key;
      int j;
      for (int i = 1; i < run_count; i++) begin
         key = run_order[i];
         j = i;
         while (j > 0 && (proc_cred[key] > proc_cred[run_order[j-1]] ||
                (tie_by_load && proc_cred[key] == proc_cred[run_order[j-1]] &&
                 key < run_order[j-1]))) begin
            run_order[j] = run_order[j-1];
            j--;
         end
         run_order[j] = key;
      end
   endfunction

   function automatic void drop_head(bit keep_at_back);
      logic [2:0] h;
      h = run_order[0];
      for (int i = 0; i < run_count - 1; i++) run_order[i] = run_order[i+1];
      if (keep_at_back) run_order[run_count-1] = h;
      else run_count--;
   endfunction

   function automatic void run_tick();
      int active;
      logic [2:0] s;
      active = 0;
      for (int i = 0; i < run_count; i++) begin
         s = run_order[i];
         if (proc_st[s] == PS_BLOCK) begin
            proc_io_left[s] = proc_io_left[s] - 16'd1;
            if (proc_io_left[s] == 0) begin
               proc_st[s] = PS_WAIT;
               proc_io_left[s] = 16'(proc_io[s]);
               proc_burst_left[s] = 16'(proc_burst[s]);
            end
         end
         if (proc_cred[s] != 0 && proc_st[s] != PS_BLOCK) active++;
      end
      if (active == 0) begin
         for (int i = 0; i < run_count; i++) begin
            s = run_order[i];
            proc_cred[s] = clamp_cred(proc_cred[s] / 2 + int'(proc_prio[s]));
         end
         sort_by_credits(1'b0);
      end
      s = run_order[0];
      if (proc_st[s] == PS_WAIT) proc_st[s] = PS_RUN;
      if (proc_st[s] == PS_RUN) begin
         proc_burst_left[s] = proc_burst_left[s] - 16'd1;
         proc_cred[s] = clamp_cred(proc_cred[s] - 1);
         proc_cpu_left[s] = proc_cpu_left[s] - 12'd1;
         if (proc_cpu_left[s] == 0) begin
            drop_head(1'b0);
            sort_by_credits(1'b0);
         end else if (proc_burst_left[s] == 0) begin
            proc_st[s] = PS_BLOCK;
            drop_head(1'b1);
         end else if (proc_cred[s] == 0) begin
            proc_st[s] = PS_WAIT;
            drop_head(1'b1);
            sort_by_credits(1'b0);
         end
      end else if (proc_st[s] == PS_BLOCK) begin
         drop_head(1'b1);
      end
   endfunction

   // work out the words one command produces
   function automatic void schedule_step(sched_cmd_type c);
      list_word_type w;
      logic [2:0] s;
      w = '{default: '0};
      w.last = 1'b1;
      if (c.cmd == CMD_LOAD) begin
         if (loaded >= MAX_PROCESSES || run_count >= MAX_PROCESSES) begin
            w.rejected = 1'b1;
         end else begin
            s = 3'(loaded);
            proc_st[s] = PS_WAIT;
            proc_prio[s] = c.prio;
            proc_cred[s] = int'(c.prio);
            proc_burst[s] = c.burst;
            proc_burst_left[s] = 16'(c.burst);
            proc_io[s] = c.io;
            proc_io_left[s] = 16'(c.io);
            proc_cpu_left[s] = c.cpu;
            run_order[run_count] = s;
            run_count++;
            loaded++;
            sort_by_credits(1'b1);
            w.index = s;
         end
         add_word(w);
         return;
      end
      if (run_count != 0) run_tick();
      if (run_count == 0) begin
         add_word(w);
         return;
      end
      for (int i = 0; i < run_count; i++) begin
         s = run_order[i];
         w.present = 1'b1;
         w.index = s;
         w.pstate = proc_st[s];
         w.credits = 8'(proc_cred[s]);
         w.burst_left = proc_burst_left[s];
         w.io_left = proc_io_left[s];
         w.cpu_left = proc_cpu_left[s];
         w.prio = proc_prio[s];
         w.rejected = 1'b0;
         w.last = (i == run_count - 1);
         add_word(w);
      end
   endfunction

   // driver: bursts of words with random gaps
   int burst_left_cnt = 1;
   int gap_cnt = 0;
   always @(posedge clock) begin
      sched_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            c.cmd = req_command;
            c.prio = req_priority_req;
            c.burst = req_burst_length;
            c.io = req_io_time;
            c.cpu = req_cpu_time;
            schedule_step(c);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].drain || expected_words.size() == 0)) begin
               c = pending_cmds[0];
               pending_cmds.delete(0);
               req_valid <= 1'b1;
               req_command <= c.cmd;
               req_priority_req <= c.prio;
               req_burst_length <= c.burst;
               req_io_time <= c.io;
               req_cpu_time <= c.cpu;
               burst_left_cnt--;
               if (burst_left_cnt <= 0) begin
                  burst_left_cnt = $urandom_range(1, 12);
                  gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: own stall pattern, one long hold once 150 words have come back
   int  hold_cnt = 0;
   bit  hold_done = 0;
   int  stall_mode = 0;
   always @(posedge clock) begin
      list_word_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            word_count++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: index %0d", rsp_load_index);
               error_count++;
            end else begin
               e = expected_words[0];
               expected_words.delete(0);
               if (rsp_present !== e.present) begin
                  $error("present exp %0d got %0d", e.present, rsp_present);
                  error_count++;
               end
               if (rsp_load_index !== e.index) begin
                  $error("load_index exp %0d got %0d", e.index, rsp_load_index);
                  error_count++;
               end
               if (rsp_proc_state !== e.pstate) begin
                  $error("proc_state exp %0d got %0d", e.pstate, rsp_proc_state);
                  error_count++;
               end
               if (rsp_credits !== e.credits) begin
                  $error("credits exp %0d got %0d", e.credits, rsp_credits);
                  error_count++;
               end
               if (rsp_burst_left !== e.burst_left) begin
                  $error("burst_left exp %0d got %0d", e.burst_left, rsp_burst_left);
                  error_count++;
               end
               if (rsp_io_left !== e.io_left) begin
                  $error("io_left exp %0d got %0d", e.io_left, rsp_io_left);
                  error_count++;
               end
               if (rsp_cpu_left !== e.cpu_left) begin
                  $error("cpu_left exp %0d got %0d", e.cpu_left, rsp_cpu_left);
                  error_count++;
               end
               if (rsp_prio_out !== e.prio) begin
                  $error("prio_out exp %0d got %0d", e.prio, rsp_prio_out);
                  error_count++;
               end
               if (rsp_load_rejected !== e.rejected) begin
                  $error("load_rejected exp %0d got %0d", e.rejected, rsp_load_rejected);
                  error_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (!hold_done && word_count >= 150) begin
            hold_done = 1;
            hold_cnt = HOLD_CYCLES;
         end
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (stall_mode == 0) begin
            rsp_stall <= 1'b0;
         end else if (stall_mode == 1) begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end else begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic sched_cmd_type make_cmd(logic cmd, int prio, int burst, int io,
                                              int cpu, bit drain);
      sched_cmd_type c;
      c.cmd = cmd;
      c.prio = 5'(prio);
      c.burst = 8'(burst);
      c.io = 8'(io);
      c.cpu = 12'(cpu);
      c.drain = drain;
      return c;
   endfunction

   initial begin
      sched_cmd_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // tick on empty list, then loads at the field extremes
      add_cmd(make_cmd(CMD_TICK, 31, 255, 255, 4095, 0));
      add_cmd(make_cmd(CMD_LOAD, 31, 0, 1, 3, 0));
      add_cmd(make_cmd(CMD_LOAD, 0, 2, 255, 4095, 0));
      add_cmd(make_cmd(CMD_LOAD, 1, 255, 0, 0, 0));
      add_cmd(make_cmd(CMD_LOAD, 31, 1, 2, 1, 0));
      for (int i = 0; i < 14; i++)
         add_cmd(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(CMD_LOAD, 16, 128, 128, 2048, 1));
      add_cmd(make_cmd(CMD_TICK, 21, 85, 170, 2730, 0));

      for (int i = 0; i < 360; i++) begin
         c.cmd = ($urandom_range(0, 11) == 0) ? CMD_LOAD : CMD_TICK;
         c.prio = 5'($urandom_range(0, 31));
         c.burst = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 6));
         c.io = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 8));
         c.cpu = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(1, 80));
         c.drain = (i == 250);
         add_cmd(c);
      end

      // wait for the queue to drain and every word to come back
      while (pending_cmds.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
